// ===== rtl/cartesian_grid_sequencer_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Cartesian grid sequencer assertion macros
// Shared concurrent assertion helpers; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef CARTESIAN_GRID_SEQUENCER_UNIT_DEFINES_SVH
`define CARTESIAN_GRID_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define CGS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cgs implication check failed");
// Next-cycle implication, checked outside reset.
`define CGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cgs next-cycle check failed");
`else
`define CGS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CGS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/cgs_pkg.sv =====
// ---------------------------------------------------------------------------
// Cartesian grid sequencer package
// Widths, reset values, register indexes and gate mode codes.
// ---------------------------------------------------------------------------
package cgs_pkg;

    localparam int LANES             = 4;
    localparam int GRID_SIZE_DEFAULT = 4;
    localparam int CELL_W            = 4;
    localparam int GRID_CELLS        = 16;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 16;
    localparam int PULSE_W           = 16;

    localparam logic [PULSE_W-1:0] PULSE_TICKS_RESET = 16'd48;
    localparam logic [1:0]         RUN_RESET         = 2'b11;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GATE_MODE   = 2'd0,
        REG_IGNORE_GATE = 2'd1,
        REG_PULSE_TICKS = 2'd2
    } cfg_reg_t;

    // Gate filter modes; the unused code behaves as continuous
    typedef enum logic [1:0] {
        GATE_TRIGGER    = 2'd0,
        GATE_RETRIGGER  = 2'd1,
        GATE_CONTINUOUS = 2'd2
    } gate_mode_t;

endpackage

// ===== rtl/cartesian_grid_sequencer_unit.sv =====
// ---------------------------------------------------------------------------
// Cartesian grid sequencer unit
// Four-lane step sequencer over a grid of gated cells, one sample tick per item.
// ---------------------------------------------------------------------------
// Each input item is one sample tick of thresholded levels. The unit takes
// one item every clock cycle and gives one result item per input item in the
// cycle after acceptance. All edge detection, cursor moves, pulse timing and
// gate lookup run in one pass of small logic ahead of a single result
// register; in_ready drops only while that register holds a result the
// downstream side has not yet taken. Configuration registers (gate mode,
// pitch ignore flag, pulse length) are written through cfg_we/cfg_index/
// cfg_data and should be changed only while the unit is idle. GRID_SIZE sets
// where the cursors wrap; cell indices keep four cells per row and are
// reported modulo 16.
`include "cartesian_grid_sequencer_unit_defines.svh"

module cartesian_grid_sequencer_unit
    import cgs_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // input item channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  run_line_level,
    input  logic                  run_column_level,
    input  logic                  reset_all_line_level,
    input  logic                  reset_all_column_level,
    input  logic [LANES-1:0]      reset_line_levels,
    input  logic [LANES-1:0]      reset_column_levels,
    input  logic [LANES-1:0]      right_levels,
    input  logic [LANES-1:0]      left_levels,
    input  logic [LANES-1:0]      down_levels,
    input  logic [LANES-1:0]      up_levels,
    input  logic [15:0]           clock_patched,
    input  logic [15:0]           gate_button_levels,

    // result item channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LANES-1:0]      vertical_gates,
    output logic [LANES-1:0]      horizontal_gates,
    output logic [15:0]           vertical_cells,
    output logic [15:0]           horizontal_cells,
    output logic [LANES-1:0]      vertical_pitch_update,
    output logic [LANES-1:0]      horizontal_pitch_update,
    output logic [15:0]           gate_states,
    output logic [1:0]            running_flags
);

    localparam int POS_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(GRID_SIZE - 1);

    // -----------------------------------------------------------------------
    // Cursor step helpers: wrap at the last grid position
    // -----------------------------------------------------------------------
    function automatic logic [POS_W-1:0] step_fwd(input logic [POS_W-1:0] p);
        return (p >= LAST_POS) ? '0 : POS_W'(p + 1'b1);
    endfunction

    function automatic logic [POS_W-1:0] step_back(input logic [POS_W-1:0] p);
        return (p == '0) ? LAST_POS : POS_W'(p - 1'b1);
    endfunction

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic [1:0]         gate_mode_reg;
    logic               ignore_gate_reg;
    logic [PULSE_W-1:0] pulse_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_mode_reg   <= GATE_TRIGGER;
            ignore_gate_reg <= 1'b0;
            pulse_ticks_reg <= PULSE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GATE_MODE:   gate_mode_reg   <= cfg_data[1:0];
                REG_IGNORE_GATE: ignore_gate_reg <= cfg_data[0];
                REG_PULSE_TICKS: pulse_ticks_reg <= cfg_data[PULSE_W-1:0];
                default:         ; // drop writes beyond the register list
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Sequencer state
    // -----------------------------------------------------------------------
    logic [3:0]           glob_hist_reg,  glob_hist_next;
    logic [2*LANES-1:0]   lres_hist_reg,  lres_hist_next;
    logic [15:0]          clk_hist_reg,   clk_hist_next;
    logic [15:0]          btn_hist_reg,   btn_hist_next;
    logic [POS_W-1:0]     hpos_reg [LANES];
    logic [POS_W-1:0]     hpos_next [LANES];
    logic [POS_W-1:0]     vpos_reg [LANES];
    logic [POS_W-1:0]     vpos_next [LANES];
    logic [GRID_CELLS-1:0] gates_reg,     gates_next;
    logic [1:0]           run_reg,        run_next;
    logic [PULSE_W-1:0]   pulse_rem_reg,  pulse_rem_next;

    // result register
    logic                 out_valid_reg;
    logic [LANES-1:0]     vg_reg, hg_reg, vp_reg, hp_reg;
    logic [15:0]          vc_reg, hc_reg;
    logic [LANES-1:0]     vg_next, hg_next, vp_next, hp_next;
    logic [15:0]          vc_next, hc_next;

    logic                 accept;

    // combinational intermediates
    logic [3:0]           glob_lvl;
    logic [3:0]           glob_rise;
    logic [2*LANES-1:0]   lres_lvl;
    logic [2*LANES-1:0]   lres_rise;
    logic [15:0]          clk_lvl;
    logic [15:0]          clk_mask;
    logic [15:0]          clk_rise;
    logic [PULSE_W-1:0]   pulse_loaded;
    logic                 pulse;
    logic                 pos_in_range;

    // Accept a new item whenever the result register is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic [CELL_W-1:0] vcell;
        logic [CELL_W-1:0] hcell;
        logic              gv;
        logic              gh;

        // run button edges toggle the run flags
        glob_lvl       = {reset_all_column_level, reset_all_line_level,
                          run_column_level, run_line_level};
        glob_rise      = glob_lvl & ~glob_hist_reg;
        glob_hist_next = glob_lvl;
        run_next       = run_reg ^ glob_rise[1:0];

        // lane reset edges
        lres_lvl       = {reset_column_levels, reset_line_levels};
        lres_rise      = lres_lvl & ~lres_hist_reg;
        lres_hist_next = lres_lvl;

        // sample only patched clocks whose axis runs; hold the rest
        clk_lvl       = {up_levels, down_levels, left_levels, right_levels};
        clk_mask      = {clock_patched[15:8] & {8{run_next[1]}},
                         clock_patched[7:0]  & {8{run_next[0]}}};
        clk_rise      = clk_lvl & ~clk_hist_reg & clk_mask;
        clk_hist_next = (clk_hist_reg & ~clk_mask) | (clk_lvl & clk_mask);

        // reset first, then right, left, down, up
        pos_in_range = 1'b1;
        for (int i = 0; i < LANES; i++)
        begin
            hpos_next[i] = (lres_rise[i] || glob_rise[2]) ? '0 : hpos_reg[i];
            vpos_next[i] = (lres_rise[i+LANES] || glob_rise[3]) ? '0 : vpos_reg[i];
            if (clk_rise[i])
                hpos_next[i] = step_fwd(hpos_next[i]);
            if (clk_rise[i+LANES])
                hpos_next[i] = step_back(hpos_next[i]);
            if (clk_rise[i+2*LANES])
                vpos_next[i] = step_fwd(vpos_next[i]);
            if (clk_rise[i+3*LANES])
                vpos_next[i] = step_back(vpos_next[i]);
            pos_in_range = pos_in_range && (hpos_reg[i] <= LAST_POS)
                                        && (vpos_reg[i] <= LAST_POS);
        end

        // any move (even a cancelled one) restarts the pulse
        pulse_loaded   = ((|clk_rise) && (pulse_ticks_reg > pulse_rem_reg))
                         ? pulse_ticks_reg : pulse_rem_reg;
        pulse          = (pulse_loaded != '0);
        pulse_rem_next = pulse ? PULSE_W'(pulse_loaded - 1'b1) : pulse_loaded;

        // gate buttons toggle cell gates
        btn_hist_next = gate_button_levels;
        gates_next    = gates_reg ^ (gate_button_levels & ~btn_hist_reg);

        // per-lane results
        vg_next = '0;
        hg_next = '0;
        vp_next = '0;
        hp_next = '0;
        vc_next = '0;
        hc_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            vcell = CELL_W'(i) + (CELL_W'(vpos_next[i]) << 2);
            hcell = CELL_W'(hpos_next[i]) + CELL_W'(i << 2);
            // vertical lanes follow the line-run flag
            gv = run_next[0] && gates_next[vcell];
            gh = run_next[1] && gates_next[hcell];
            case (gate_mode_reg)
                GATE_TRIGGER:
                begin
                    gv = gv && pulse;
                    gh = gh && pulse;
                end
                GATE_RETRIGGER:
                begin
                    gv = gv && !pulse;
                    gh = gh && !pulse;
                end
                default: ; // continuous: gate passes as is
            endcase
            vg_next[i] = gv;
            hg_next[i] = gh;
            vp_next[i] = gv || ignore_gate_reg;
            hp_next[i] = gh || ignore_gate_reg;
            vc_next[CELL_W*i +: CELL_W] = vcell;
            hc_next[CELL_W*i +: CELL_W] = hcell;
        end
    end

    // Advance state only on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glob_hist_reg <= '0;
            lres_hist_reg <= '0;
            clk_hist_reg  <= '0;
            btn_hist_reg  <= '0;
            gates_reg     <= '0;
            run_reg       <= RUN_RESET;
            pulse_rem_reg <= '0;
            for (int i = 0; i < LANES; i++)
            begin
                hpos_reg[i] <= '0;
                vpos_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            glob_hist_reg <= glob_hist_next;
            lres_hist_reg <= lres_hist_next;
            clk_hist_reg  <= clk_hist_next;
            btn_hist_reg  <= btn_hist_next;
            gates_reg     <= gates_next;
            run_reg       <= run_next;
            pulse_rem_reg <= pulse_rem_next;
            for (int i = 0; i < LANES; i++)
            begin
                hpos_reg[i] <= hpos_next[i];
                vpos_reg[i] <= vpos_next[i];
            end
        end
    end

    // Result valid: set on accept, drop when taken without a new item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vg_reg <= vg_next;
            hg_reg <= hg_next;
            vp_reg <= vp_next;
            hp_reg <= hp_next;
            vc_reg <= vc_next;
            hc_reg <= hc_next;
        end
    end

    assign out_valid               = out_valid_reg;
    assign vertical_gates          = vg_reg;
    assign horizontal_gates        = hg_reg;
    assign vertical_cells          = vc_reg;
    assign horizontal_cells        = hc_reg;
    assign vertical_pitch_update   = vp_reg;
    assign horizontal_pitch_update = hp_reg;
    // state registers already hold this item's values until the next accept
    assign gate_states             = gates_reg;
    assign running_flags           = run_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `CGS_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid)
    `CGS_ASSERT_IMPLY(a_vgate_needs_line_run, clk, rst_n, out_valid && !running_flags[0], vertical_gates == '0)
    `CGS_ASSERT_IMPLY(a_hgate_needs_col_run, clk, rst_n, out_valid && !running_flags[1], horizontal_gates == '0)
    `CGS_ASSERT_IMPLY(a_pitch_covers_gate, clk, rst_n, out_valid, ((vertical_pitch_update & vertical_gates) == vertical_gates) && ((horizontal_pitch_update & horizontal_gates) == horizontal_gates))
    `CGS_ASSERT_IMPLY(a_cursor_in_grid, clk, rst_n, 1'b1, pos_in_range)

endmodule

// ===== tb/cgs_tick_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cartesian grid sequencer tick checker
// Tracks register writes and both item channels, predicts each result item
// from a private copy of the sequencer state, compares it field by field.
// ---------------------------------------------------------------------------
module cgs_tick_checker
    import cgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  run_line_level,
    input  logic                  run_column_level,
    input  logic                  reset_all_line_level,
    input  logic                  reset_all_column_level,
    input  logic [LANES-1:0]      reset_line_levels,
    input  logic [LANES-1:0]      reset_column_levels,
    input  logic [LANES-1:0]      right_levels,
    input  logic [LANES-1:0]      left_levels,
    input  logic [LANES-1:0]      down_levels,
    input  logic [LANES-1:0]      up_levels,
    input  logic [15:0]           clock_patched,
    input  logic [15:0]           gate_button_levels,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [LANES-1:0]      vertical_gates,
    input  logic [LANES-1:0]      horizontal_gates,
    input  logic [15:0]           vertical_cells,
    input  logic [15:0]           horizontal_cells,
    input  logic [LANES-1:0]      vertical_pitch_update,
    input  logic [LANES-1:0]      horizontal_pitch_update,
    input  logic [15:0]           gate_states,
    input  logic [1:0]            running_flags,
    output int                    errors,
    output int                    pending
);

    localparam logic [1:0] LAST_POS = 2'(GRID_SIZE_DEFAULT - 1);

    typedef struct packed {
        logic [3:0]  glob;      // {reset all column, reset all line, run column, run line}
        logic [7:0]  lane_rst;  // {column resets, line resets}
        logic [15:0] clocks;    // {up, down, left, right}
        logic [15:0] patched;
        logic [15:0] buttons;
    } tick_levels_t;

    typedef struct packed {
        logic [3:0]  vgates;
        logic [3:0]  hgates;
        logic [15:0] vcells;
        logic [15:0] hcells;
        logic [3:0]  vpitch;
        logic [3:0]  hpitch;
        logic [15:0] cell_gates;
        logic [1:0]  running;
    } grid_result_t;

    // register copy
    logic [1:0]  mode_code;
    logic        pitch_ignores_gate;
    logic [15:0] pulse_len;

    // sequencer state copy
    logic [3:0]  glob_hist;
    logic [7:0]  lane_rst_hist;
    logic [15:0] clock_hist;
    logic [15:0] button_hist;
    logic [1:0]  hpos [LANES];
    logic [1:0]  vpos [LANES];
    logic [15:0] gates;
    logic [1:0]  running;
    logic [15:0] pulse_left;

    grid_result_t expected_results [$];

    function automatic logic [1:0] step_fwd(logic [1:0] p);
        return (p >= LAST_POS) ? 2'd0 : p + 2'd1;
    endfunction

    function automatic logic [1:0] step_back(logic [1:0] p);
        return (p == 2'd0) ? LAST_POS : p - 2'd1;
    endfunction

    // Advance the grid by one sample tick and return what it should report.
    function automatic grid_result_t advance_grid(tick_levels_t t);
        logic [3:0]   grise;
        logic [7:0]   lrise;
        logic [15:0]  mask;
        logic [15:0]  crise;
        logic [15:0]  brise;
        logic [3:0]   vcell;
        logic [3:0]   hcell;
        logic         pulse;
        logic         gv;
        logic         gh;
        grid_result_t r;

        grise = t.glob & ~glob_hist;
        glob_hist = t.glob;
        running ^= grise[1:0];

        lrise = t.lane_rst & ~lane_rst_hist;
        lane_rst_hist = t.lane_rst;
        for (int i = 0; i < LANES; i++)
        begin
            if (lrise[i] || grise[2])
                hpos[i] = 2'd0;
            if (lrise[i+4] || grise[3])
                vpos[i] = 2'd0;
        end

        // a stopped axis leaves its clock history frozen
        mask = t.patched & {{8{running[1]}}, {8{running[0]}}};
        crise = t.clocks & ~clock_hist & mask;
        clock_hist = (clock_hist & ~mask) | (t.clocks & mask);

        for (int i = 0; i < LANES; i++)
        begin
            if (crise[i])
                hpos[i] = step_fwd(hpos[i]);
            if (crise[i+4])
                hpos[i] = step_back(hpos[i]);
            if (crise[i+8])
                vpos[i] = step_fwd(vpos[i]);
            if (crise[i+12])
                vpos[i] = step_back(vpos[i]);
        end

        if ((crise != 16'd0) && (pulse_len > pulse_left))
            pulse_left = pulse_len;
        pulse = (pulse_left != 16'd0);
        if (pulse)
            pulse_left = pulse_left - 16'd1;

        brise = t.buttons & ~button_hist;
        button_hist = t.buttons;
        gates ^= brise;

        r = '0;
        for (int i = 0; i < LANES; i++)
        begin
            vcell = {vpos[i], 2'(i)};
            hcell = {2'(i), hpos[i]};
            gv = running[0] && gates[vcell];
            gh = running[1] && gates[hcell];
            if (mode_code == GATE_TRIGGER)
            begin
                gv = gv && pulse;
                gh = gh && pulse;
            end
            else if (mode_code == GATE_RETRIGGER)
            begin
                gv = gv && !pulse;
                gh = gh && !pulse;
            end
            r.vgates[i] = gv;
            r.hgates[i] = gh;
            r.vpitch[i] = gv || pitch_ignores_gate;
            r.hpitch[i] = gh || pitch_ignores_gate;
            r.vcells[4*i +: 4] = vcell;
            r.hcells[4*i +: 4] = hcell;
        end
        r.cell_gates = gates;
        r.running = running;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            if (errors < 10)
                $display("%0t %s: expected %h got %h", $realtime, field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grid_result_t want;
        tick_levels_t tick;

        if (!rst_n)
        begin
            mode_code = GATE_TRIGGER;
            pitch_ignores_gate = 1'b0;
            pulse_len = PULSE_TICKS_RESET;
            glob_hist = '0;
            lane_rst_hist = '0;
            clock_hist = '0;
            button_hist = '0;
            for (int i = 0; i < LANES; i++)
            begin
                hpos[i] = 2'd0;
                vpos[i] = 2'd0;
            end
            gates = '0;
            running = RUN_RESET;
            pulse_left = '0;
            expected_results.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t result item with nothing expected", $realtime);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    note_mismatch("vertical_gates", 16'(want.vgates), 16'(vertical_gates));
                    note_mismatch("horizontal_gates", 16'(want.hgates),
                                  16'(horizontal_gates));
                    note_mismatch("vertical_cells", want.vcells, vertical_cells);
                    note_mismatch("horizontal_cells", want.hcells, horizontal_cells);
                    note_mismatch("vertical_pitch_update", 16'(want.vpitch),
                                  16'(vertical_pitch_update));
                    note_mismatch("horizontal_pitch_update", 16'(want.hpitch),
                                  16'(horizontal_pitch_update));
                    note_mismatch("gate_states", want.cell_gates, gate_states);
                    note_mismatch("running_flags", 16'(want.running), 16'(running_flags));
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GATE_MODE:   mode_code = cfg_data[1:0];
                    REG_IGNORE_GATE: pitch_ignores_gate = cfg_data[0];
                    REG_PULSE_TICKS: pulse_len = cfg_data[PULSE_W-1:0];
                    default:         ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                tick.glob = {reset_all_column_level, reset_all_line_level,
                             run_column_level, run_line_level};
                tick.lane_rst = {reset_column_levels, reset_line_levels};
                tick.clocks = {up_levels, down_levels, left_levels, right_levels};
                tick.patched = clock_patched;
                tick.buttons = gate_button_levels;
                expected_results.push_back(advance_grid(tick));
            end

            pending = expected_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cartesian grid sequencer unit testbench
// Drives sample ticks through the sequencer under several register settings
// and lets the tick checker compare every result item against its own model.
// ---------------------------------------------------------------------------
module tb;
    import cgs_pkg::*;

    // Gate mode code with no name in the package; the unit treats it as continuous
    localparam logic [1:0] GATE_UNUSED = 2'd3;

    localparam int IDLE_PCT       = 22;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 7;
    localparam int PHASE_TICKS    = 210;

    // One sample tick of levels as the sender presents it
    typedef struct packed {
        logic        run_line;
        logic        run_column;
        logic        reset_all_line;
        logic        reset_all_column;
        logic [3:0]  reset_lines;
        logic [3:0]  reset_columns;
        logic [3:0]  right;
        logic [3:0]  left;
        logic [3:0]  down;
        logic [3:0]  up;
        logic [15:0] patched;
        logic [15:0] buttons;
    } stim_tick_t;

    localparam int TICK_W = $bits(stim_tick_t);

    // Register settings walked through after the first phase; the last one
    // runs with no idling on either side.
    localparam logic [1:0] PLAN_MODE [PHASES] = '{GATE_RETRIGGER, GATE_CONTINUOUS,
                                                  GATE_TRIGGER, GATE_UNUSED,
                                                  GATE_TRIGGER, GATE_RETRIGGER,
                                                  GATE_CONTINUOUS};
    localparam logic PLAN_IGNORE [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam logic [15:0] PLAN_PULSE [PHASES] = '{16'd1, 16'hFFFF, 16'd1, 16'd5,
                                                    16'd0, 16'd3, 16'd48};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_GATE_MODE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  out_ready = 1'b0;
    stim_tick_t            cur       = '0;
    logic                  idling    = 1'b0;

    logic                  in_ready;
    logic                  out_valid;
    logic [LANES-1:0]      vertical_gates;
    logic [LANES-1:0]      horizontal_gates;
    logic [15:0]           vertical_cells;
    logic [15:0]           horizontal_cells;
    logic [LANES-1:0]      vertical_pitch_update;
    logic [LANES-1:0]      horizontal_pitch_update;
    logic [15:0]           gate_states;
    logic [1:0]            running_flags;

    int errors;
    int pending;
    int idle_cycles = 0;

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    cartesian_grid_sequencer_unit i_dut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cfg_we                  (cfg_we),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .in_valid                (in_valid),
        .in_ready                (in_ready),
        .run_line_level          (cur.run_line),
        .run_column_level        (cur.run_column),
        .reset_all_line_level    (cur.reset_all_line),
        .reset_all_column_level  (cur.reset_all_column),
        .reset_line_levels       (cur.reset_lines),
        .reset_column_levels     (cur.reset_columns),
        .right_levels            (cur.right),
        .left_levels             (cur.left),
        .down_levels             (cur.down),
        .up_levels               (cur.up),
        .clock_patched           (cur.patched),
        .gate_button_levels      (cur.buttons),
        .out_valid               (out_valid),
        .out_ready               (out_ready),
        .vertical_gates          (vertical_gates),
        .horizontal_gates        (horizontal_gates),
        .vertical_cells          (vertical_cells),
        .horizontal_cells        (horizontal_cells),
        .vertical_pitch_update   (vertical_pitch_update),
        .horizontal_pitch_update (horizontal_pitch_update),
        .gate_states             (gate_states),
        .running_flags           (running_flags)
    );

    cgs_tick_checker i_checker (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cfg_we                  (cfg_we),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .in_valid                (in_valid),
        .in_ready                (in_ready),
        .run_line_level          (cur.run_line),
        .run_column_level        (cur.run_column),
        .reset_all_line_level    (cur.reset_all_line),
        .reset_all_column_level  (cur.reset_all_column),
        .reset_line_levels       (cur.reset_lines),
        .reset_column_levels     (cur.reset_columns),
        .right_levels            (cur.right),
        .left_levels             (cur.left),
        .down_levels             (cur.down),
        .up_levels               (cur.up),
        .clock_patched           (cur.patched),
        .gate_button_levels      (cur.buttons),
        .out_valid               (out_valid),
        .out_ready               (out_ready),
        .vertical_gates          (vertical_gates),
        .horizontal_gates        (horizontal_gates),
        .vertical_cells          (vertical_cells),
        .horizontal_cells        (horizontal_cells),
        .vertical_pitch_update   (vertical_pitch_update),
        .horizontal_pitch_update (horizontal_pitch_update),
        .gate_states             (gate_states),
        .running_flags           (running_flags),
        .errors                  (errors),
        .pending                 (pending)
    );

    // Receiver: stall at random while idling is on, else take every item.
    always @(negedge clk)
        out_ready <= !idling || ($urandom_range(99) >= IDLE_PCT);

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Build a tick from grouped levels; the groupings follow the unit's own
    // bit layouts so directed ticks read compactly.
    //   glob     {reset all column, reset all line, run column, run line}
    //   lane_rst {column resets, line resets}
    //   clocks   {up, down, left, right}, same layout as clock_patched
    function automatic stim_tick_t levels(logic [3:0] glob, logic [7:0] lane_rst,
                                          logic [15:0] clocks, logic [15:0] patched,
                                          logic [15:0] buttons);
        stim_tick_t t;
        t.run_line         = glob[0];
        t.run_column       = glob[1];
        t.reset_all_line   = glob[2];
        t.reset_all_column = glob[3];
        t.reset_lines      = lane_rst[3:0];
        t.reset_columns    = lane_rst[7:4];
        t.right            = clocks[3:0];
        t.left             = clocks[7:4];
        t.down             = clocks[11:8];
        t.up               = clocks[15:12];
        t.patched          = patched;
        t.buttons          = buttons;
        return t;
    endfunction

    // Sixteen bits, each set with the given chance in percent.
    function automatic logic [15:0] sparse_bits(int pct);
        logic [15:0] m;
        for (int b = 0; b < 16; b++)
            m[b] = ($urandom_range(99) < pct);
        return m;
    endfunction

    // Offer one item: idle at random first, then hold valid and payload
    // until the unit takes it. Return at the falling edge after acceptance
    // without touching valid; the next call or a drain decides its level.
    task automatic send_tick(input stim_tick_t t);
        while (idling && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cur <= t;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every result item has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Write one register; lower the enable on the next step so back-to-back
    // writes never assign it twice in one step.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Random ticks as slowly drifting levels. Clock activity comes in bursts
    // of different densities so the move pulse both stays up and runs out;
    // a few ticks are pure noise.
    task automatic run_random(input int count);
        stim_tick_t  t;
        logic [15:0] flips;
        int          clock_pct;
        int          burst_left;

        t = cur;
        clock_pct = 0;
        burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(80, 10);
                case ($urandom_range(3))
                    0:       clock_pct = 0;
                    1:       clock_pct = 1;
                    2:       clock_pct = 6;
                    default: clock_pct = 35;
                endcase
            end
            burst_left--;

            if ($urandom_range(99) < 5)
                t = stim_tick_t'(TICK_W'({$urandom, $urandom}));
            else
            begin
                flips = sparse_bits(3);
                t.run_line         ^= flips[0];
                t.run_column       ^= flips[1];
                t.reset_all_line   ^= flips[2];
                t.reset_all_column ^= flips[3];
                flips = sparse_bits(4);
                t.reset_lines   ^= flips[3:0];
                t.reset_columns ^= flips[7:4];
                flips = sparse_bits(clock_pct);
                t.right ^= flips[3:0];
                t.left  ^= flips[7:4];
                t.down  ^= flips[11:8];
                t.up    ^= flips[15:12];
                t.buttons ^= sparse_bits(4);
                // keep the jacks mostly patched, with occasional drift
                if ($urandom_range(99) < 3)
                    t.patched = 16'hFFFF;
                else
                    t.patched ^= sparse_bits(1);
            end
            send_tick(t);
        end
    endtask

    initial
    begin
        // Start in reset and release it on a falling edge.
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        idling = 1'b1;

        // Directed ticks under reset register values: trigger mode, pulse 48.
        send_tick(levels(4'b0000, 8'h00, 16'h0000, 16'h0000, 16'h0000));
        // single moves on each clock group
        send_tick(levels(4'b0000, 8'h00, 16'h000F, 16'hFFFF, 16'h0000));
        send_tick(levels(4'b0000, 8'h00, 16'h00F0, 16'hFFFF, 16'h0000));
        send_tick(levels(4'b0000, 8'h00, 16'h0F00, 16'hFFFF, 16'h0000));
        send_tick(levels(4'b0000, 8'h00, 16'hF000, 16'hFFFF, 16'h0000));
        // opposite clocks cancel but restart the pulse
        send_tick(levels(4'b0000, 8'h00, 16'h00FF, 16'hFFFF, 16'h0000));
        send_tick(levels(4'b0000, 8'h00, 16'hFF00, 16'hFFFF, 16'h0000));
        // turn every cell gate on
        send_tick(levels(4'b0000, 8'h00, 16'h0000, 16'hFFFF, 16'hFFFF));
        // wrap left from zero, then right from the last column
        send_tick(levels(4'b0000, 8'h00, 16'h00F0, 16'hFFFF, 16'h0000));
        send_tick(levels(4'b0000, 8'h00, 16'h000F, 16'hFFFF, 16'hA5A5));
        send_tick(levels(4'b0000, 8'h00, 16'hF000, 16'hFFFF, 16'h0000));
        // stop the line axis; its clocks are ignored and history frozen
        send_tick(levels(4'b0001, 8'h00, 16'h0000, 16'hFFFF, 16'h0000));
        send_tick(levels(4'b0001, 8'h00, 16'h00FF, 16'hFFFF, 16'h0000));
        // stop the column axis too
        send_tick(levels(4'b0010, 8'h00, 16'hFF0F, 16'hFFFF, 16'h0000));
        // restart the line axis: the held right level now counts as an edge
        send_tick(levels(4'b0001, 8'h00, 16'hFF0F, 16'hFFFF, 16'h0000));
        // restart the column axis: up rises against its frozen history
        send_tick(levels(4'b0010, 8'h00, 16'hF000, 16'hFFFF, 16'h0000));
        // global resets together with clock edges: reset first, then move
        send_tick(levels(4'b1100, 8'h00, 16'h0F0F, 16'hFFFF, 16'h0000));
        // per-lane resets with moves the other way
        send_tick(levels(4'b0000, 8'hFF, 16'hF0F0, 16'hFFFF, 16'h0000));
        // unpatched clocks never move
        send_tick(levels(4'b0000, 8'h00, 16'hFFFF, 16'h0000, 16'hFFFF));
        // partial patching: only right and down count
        send_tick(levels(4'b0000, 8'h00, 16'hFFFF, 16'h0F0F, 16'h0000));
        // everything high: both axes stop, all resets fire
        send_tick(levels(4'b1111, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_tick(levels(4'b0011, 8'h00, 16'h0000, 16'hFFFF, 16'h0000));
        send_tick(levels(4'b0000, 8'h00, 16'h0000, 16'hFFFF, 16'h0000));
        // run both axes again
        send_tick(levels(4'b0011, 8'h00, 16'h0000, 16'hFFFF, 16'h0000));
        send_tick(levels(4'b0000, 8'h00, 16'h0000, 16'hFFFF, 16'h0000));

        run_random(250);

        // Walk the register plan; drain before each change so the unit is idle.
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_reg(REG_GATE_MODE, CFG_DATA_W'(PLAN_MODE[p]));
            write_reg(REG_IGNORE_GATE, CFG_DATA_W'(PLAN_IGNORE[p]));
            write_reg(REG_PULSE_TICKS, PLAN_PULSE[p]);
            idling = (p != PHASES - 1);
            run_random(PHASE_TICKS);
        end

        drain_results();
        if ((errors == 0) && (pending == 0))
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
